// File: rtl/core/srt_pkg.sv
// srt_pkg: shared types, codes and defaults for the sorted record table
// used by srt_ctrl, srt_datapath and sorted_record_table_core; no dependencies
`default_nettype none

package srt_pkg;

	// default table depth and result index width
	localparam int DEF_CAPACITY = 32;
	localparam int IDX_W        = 5;

	// result status codes
	typedef enum logic [1:0] {
		STATUS_STORED = 2'd0,
		STATUS_FULL   = 2'd1,
		STATUS_LISTED = 2'd2,
		STATUS_EMPTY  = 2'd3
	} status_t;

	// request codes
	typedef enum logic {
		MODE_INSERT = 1'b0,
		MODE_LIST   = 1'b1
	} mode_t;

	// controller states
	typedef enum logic [2:0] {
		S_IDLE,
		S_INS_SCAN,
		S_INS_PLACE,
		S_LIST,
		S_LIST_END
	} state_t;

	// input transfer
	typedef struct packed {
		mode_t              mode;
		logic [63:0]        name_head;
		logic [15:0]        name_tail;
		logic signed [31:0] age;
		logic signed [31:0] phone;
	} item_t;

	// one stored table entry
	typedef struct packed {
		logic [63:0]        name_head;
		logic [15:0]        name_tail;
		logic signed [31:0] age;
		logic signed [31:0] phone;
	} rec_t;

	// result transfer
	typedef struct packed {
		status_t            status;
		logic [IDX_W-1:0]   entry_index;
		logic [63:0]        out_name_head;
		logic [15:0]        out_name_tail;
		logic signed [31:0] out_age;
		logic signed [31:0] out_phone;
		logic               last;
	} result_t;

	// commands from controller to datapath
	typedef struct packed {
		logic load;
		logic rd_en;
		logic list_rd;
		logic list_last;
		logic wr_shift;
		logic wr_new;
		logic emit_full;
		logic emit_empty;
	} ctl_cmd_t;

endpackage

`default_nettype wire

// File: rtl/core/sorted_record_table_core.sv
// sorted_record_table_core: top level of the sorted record table
// depends on srt_pkg, srt_ctrl and srt_datapath
`default_nettype none

// A table of up to CAPACITY records kept in name order. A request is taken
// when start is high and busy is low. An insert holds busy after the
// accepting edge while the controller walks the table from the top entry
// down, one memory read and one compare per cycle, moving each larger entry
// up a slot, then writes the new record; its single result appears in the
// cycle after that write, when busy is already low. A list of n entries
// holds busy while it reads them out and gives n results, one per cycle,
// the last when busy is already low. An insert into a full table and a list
// of an empty table never raise busy; their result appears in the next
// cycle. Each result is on result for exactly one cycle with strobe high;
// the receiver has no way to hold results off and must take every one.

module sorted_record_table_core #(
	parameter int CAPACITY = srt_pkg::DEF_CAPACITY
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire srt_pkg::item_t   item,
	output logic                  busy,
	output logic                  strobe,
	output srt_pkg::result_t      result
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	srt_pkg::ctl_cmd_t cmd;
	logic [AW-1:0]     rd_addr;
	logic [AW-1:0]     wr_addr;
	logic [AW-1:0]     res_idx;
	logic              greater;

	// sequencer
	srt_ctrl #(
		.CAPACITY (CAPACITY),
		.AW       (AW),
		.CW       (CW)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.mode    (item.mode),
		.greater (greater),
		.busy    (busy),
		.cmd     (cmd),
		.rd_addr (rd_addr),
		.wr_addr (wr_addr),
		.res_idx (res_idx)
	);

	// storage and result path
	srt_datapath #(
		.CAPACITY (CAPACITY),
		.AW       (AW)
	) u_datapath (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item),
		.cmd     (cmd),
		.rd_addr (rd_addr),
		.wr_addr (wr_addr),
		.res_idx (res_idx),
		.greater (greater),
		.strobe  (strobe),
		.result  (result)
	);

endmodule

`default_nettype wire

// File: rtl/core/srt_datapath.sv
// srt_datapath: record memory, name comparator and result register
// depends on srt_pkg; driven by srt_ctrl commands
`default_nettype none

module srt_datapath #(
	parameter int CAPACITY = srt_pkg::DEF_CAPACITY,
	parameter int AW       = $clog2(CAPACITY)
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire srt_pkg::item_t   item,
	input  wire srt_pkg::ctl_cmd_t cmd,
	input  wire logic [AW-1:0]    rd_addr,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [AW-1:0]    res_idx,
	output logic                  greater,
	output logic                  strobe,
	output srt_pkg::result_t      result
);

	localparam int IdxExtW = AW + srt_pkg::IDX_W;

	srt_pkg::rec_t   mem [CAPACITY];
	srt_pkg::rec_t   rec_q;
	srt_pkg::rec_t   rd_data_q;
	logic [AW-1:0]   rd_idx_s1;
	logic            list_s1;
	logic            last_s1;
	logic            strobe_q;
	srt_pkg::result_t res_q;
	logic [IdxExtW-1:0] list_idx_ext;
	logic [IdxExtW-1:0] new_idx_ext;
	logic [79:0]     key_a;
	logic [79:0]     key_b;
	logic [79:0]     key_mask;
	logic [9:0]      keep;

	// latch the incoming record
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rec_q.name_head <= item.name_head;
			rec_q.name_tail <= item.name_tail;
			rec_q.age       <= item.age;
			rec_q.phone     <= item.phone;
		end
	end

	// record memory, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (cmd.wr_shift) begin
			mem[wr_addr] <= rd_data_q;
		end else if (cmd.wr_new) begin
			mem[wr_addr] <= rec_q;
		end
		if (cmd.rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
		if (cmd.list_rd) begin
			rd_idx_s1 <= rd_addr;
			last_s1   <= cmd.list_last;
		end
	end

	// stored name against new name, byte order with stop at a shared zero byte
	assign key_a = {rd_data_q.name_head, rd_data_q.name_tail};
	assign key_b = {rec_q.name_head, rec_q.name_tail};

	always_comb begin
		keep[9] = 1'b1;
		for (int k = 8; k >= 0; k--) begin
			keep[k] = keep[k+1] & (key_a[8*k+15 -: 8] != 8'h00);
		end
		for (int k = 0; k < 10; k++) begin
			key_mask[8*k+7 -: 8] = {8{keep[k]}};
		end
	end

	assign greater = (key_a & key_mask) > (key_b & key_mask);

	// index of a result, taken modulo the index width
	assign list_idx_ext = IdxExtW'(rd_idx_s1);
	assign new_idx_ext  = IdxExtW'(res_idx);

	// list pipeline marker
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			list_s1  <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			list_s1  <= cmd.list_rd;
			strobe_q <= list_s1 | cmd.wr_new | cmd.emit_full | cmd.emit_empty;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (list_s1) begin
			res_q.status        <= srt_pkg::STATUS_LISTED;
			res_q.entry_index   <= list_idx_ext[srt_pkg::IDX_W-1:0];
			res_q.out_name_head <= rd_data_q.name_head;
			res_q.out_name_tail <= rd_data_q.name_tail;
			res_q.out_age       <= rd_data_q.age;
			res_q.out_phone     <= rd_data_q.phone;
			res_q.last          <= last_s1;
		end else if (cmd.wr_new) begin
			res_q.status        <= srt_pkg::STATUS_STORED;
			res_q.entry_index   <= new_idx_ext[srt_pkg::IDX_W-1:0];
			res_q.out_name_head <= rec_q.name_head;
			res_q.out_name_tail <= rec_q.name_tail;
			res_q.out_age       <= rec_q.age;
			res_q.out_phone     <= rec_q.phone;
			res_q.last          <= 1'b1;
		end else if (cmd.emit_full || cmd.emit_empty) begin
			res_q.status        <= cmd.emit_full ? srt_pkg::STATUS_FULL
			                                     : srt_pkg::STATUS_EMPTY;
			res_q.entry_index   <= '0;
			res_q.out_name_head <= '0;
			res_q.out_name_tail <= '0;
			res_q.out_age       <= '0;
			res_q.out_phone     <= '0;
			res_q.last          <= 1'b1;
		end
	end

	assign strobe = strobe_q;
	assign result = res_q;

	// a listed result never collides with another result source
	a_list_alone: assert property (@(posedge clk) disable iff (!arst_n)
		list_s1 |-> !(cmd.wr_new || cmd.emit_full || cmd.emit_empty))
		else $error("list result overlaps another result");

endmodule

`default_nettype wire

// File: rtl/core/srt_ctrl.sv
// srt_ctrl: sequencer for insert scan/shift and list readout, holds entry count
// depends on srt_pkg; commands srt_datapath
`default_nettype none

module srt_ctrl #(
	parameter int CAPACITY = srt_pkg::DEF_CAPACITY,
	parameter int AW       = $clog2(CAPACITY),
	parameter int CW       = $clog2(CAPACITY + 1)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire srt_pkg::mode_t    mode,
	input  wire logic              greater,
	output logic                   busy,
	output srt_pkg::ctl_cmd_t      cmd,
	output logic [AW-1:0]          rd_addr,
	output logic [AW-1:0]          wr_addr,
	output logic [AW-1:0]          res_idx
);

	srt_pkg::state_t state_q, state_d;
	logic [AW-1:0]   ptr_q, ptr_d;
	logic [CW-1:0]   count_q, count_d;
	logic [CW-1:0]   count_m1;
	logic            full;

	assign count_m1 = count_q - CW'(1);
	assign full     = (count_q == CW'(CAPACITY));

	// state, pointer and count registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= srt_pkg::S_IDLE;
			ptr_q   <= '0;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			ptr_q   <= ptr_d;
			count_q <= count_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d = state_q;
		ptr_d   = ptr_q;
		count_d = count_q;
		cmd     = '0;
		rd_addr = ptr_q;
		wr_addr = ptr_q;
		res_idx = ptr_q;
		busy    = 1'b1;
		unique case (state_q)
			srt_pkg::S_IDLE: begin
				busy = 1'b0;
				if (start) begin
					if (mode == srt_pkg::MODE_INSERT) begin
						if (full) begin
							cmd.emit_full = 1'b1;
						end else if (count_q == '0) begin
							cmd.load = 1'b1;
							ptr_d    = '0;
							state_d  = srt_pkg::S_INS_PLACE;
						end else begin
							// scan downward from the top entry
							cmd.load  = 1'b1;
							cmd.rd_en = 1'b1;
							rd_addr   = AW'(count_m1);
							ptr_d     = AW'(count_m1);
							state_d   = srt_pkg::S_INS_SCAN;
						end
					end else begin
						if (count_q == '0) begin
							cmd.emit_empty = 1'b1;
						end else begin
							cmd.rd_en     = 1'b1;
							cmd.list_rd   = 1'b1;
							cmd.list_last = (count_q == CW'(1));
							rd_addr       = '0;
							ptr_d         = AW'(1);
							state_d       = (count_q == CW'(1)) ? srt_pkg::S_LIST_END
							                                    : srt_pkg::S_LIST;
						end
					end
				end
			end
			srt_pkg::S_INS_SCAN: begin
				if (greater) begin
					// move entry up one slot
					cmd.wr_shift = 1'b1;
					wr_addr      = ptr_q + AW'(1);
					if (ptr_q == '0) begin
						state_d = srt_pkg::S_INS_PLACE;
					end else begin
						cmd.rd_en = 1'b1;
						rd_addr   = ptr_q - AW'(1);
						ptr_d     = ptr_q - AW'(1);
					end
				end else begin
					ptr_d   = ptr_q + AW'(1);
					state_d = srt_pkg::S_INS_PLACE;
				end
			end
			srt_pkg::S_INS_PLACE: begin
				cmd.wr_new = 1'b1;
				count_d    = count_q + CW'(1);
				state_d    = srt_pkg::S_IDLE;
			end
			srt_pkg::S_LIST: begin
				cmd.rd_en     = 1'b1;
				cmd.list_rd   = 1'b1;
				cmd.list_last = (CW'(ptr_q) == count_m1);
				if (CW'(ptr_q) == count_m1) begin
					state_d = srt_pkg::S_LIST_END;
				end else begin
					ptr_d = ptr_q + AW'(1);
				end
			end
			srt_pkg::S_LIST_END: begin
				// final listed transfer leaves the result register
				state_d = srt_pkg::S_IDLE;
			end
			default: begin
				state_d = srt_pkg::S_IDLE;
			end
		endcase
	end

	// count stays within the table
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("entry count beyond capacity");

	// every placed record adds exactly one entry
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_new |=> count_q == $past(count_q) + CW'(1))
		else $error("entry count not advanced on insert");

	// reads touch only stored entries
	a_read_stored: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_en |-> CW'(rd_addr) < count_q)
		else $error("read of an unstored entry");

endmodule

`default_nettype wire

// File: tb/srt_result_checker.sv
// srt_result_checker: watches the request and result channels of the sorted record table,
// predicts every result from its own copy of the table and compares; depends on srt_pkg
`default_nettype none

module srt_result_checker #(
	parameter int CAPACITY = srt_pkg::DEF_CAPACITY
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic             busy,
	input  wire srt_pkg::item_t   item,
	input  wire logic             strobe,
	input  wire srt_pkg::result_t result,
	output int                    fail_count,
	output int                    pending,
	output int                    checked
);

	// shadow copy of the table, kept in name order
	srt_pkg::rec_t    sorted_recs [CAPACITY];
	int               stored_count;
	srt_pkg::result_t due_results [$];
	int               mismatch_total;
	int               results_seen;

	task automatic report(input string msg);
		$display("mismatch: %s", msg);
		mismatch_total++;
	endtask

	task automatic check_field(input string field, input logic [63:0] got, want);
		if (got !== want)
			report($sformatf("result %0d field %s is %h, expected %h",
				results_seen, field, got, want));
	endtask

	// byte-wise name order, stopping at a shared zero byte
	function automatic bit name_after(input logic [63:0] ah, input logic [15:0] at,
			input logic [63:0] bh, input logic [15:0] bt);
		logic [79:0] a;
		logic [79:0] b;
		logic [7:0]  x;
		logic [7:0]  y;
		a = {ah, at};
		b = {bh, bt};
		for (int k = 0; k < 10; k++) begin
			x = a[79 - 8*k -: 8];
			y = b[79 - 8*k -: 8];
			if (x != y)
				return x > y;
			if (x == 8'h00)
				return 1'b0;
		end
		return 1'b0;
	endfunction

	// work out the results of one accepted request and update the shadow table
	task automatic apply_request(input srt_pkg::item_t req);
		srt_pkg::result_t r;
		int               pos;
		r = '0;
		r.last = 1'b1;
		if (req.mode == srt_pkg::MODE_INSERT) begin
			if (stored_count >= CAPACITY) begin
				r.status = srt_pkg::STATUS_FULL;
			end else begin
				pos = 0;
				while (pos < stored_count && !name_after(sorted_recs[pos].name_head,
						sorted_recs[pos].name_tail, req.name_head, req.name_tail))
					pos++;
				for (int i = stored_count; i > pos; i--)
					sorted_recs[i] = sorted_recs[i - 1];
				sorted_recs[pos] = {req.name_head, req.name_tail, req.age, req.phone};
				stored_count++;
				r.status        = srt_pkg::STATUS_STORED;
				r.entry_index   = pos[srt_pkg::IDX_W-1:0];
				r.out_name_head = req.name_head;
				r.out_name_tail = req.name_tail;
				r.out_age       = req.age;
				r.out_phone     = req.phone;
			end
			due_results.push_back(r);
		end else if (stored_count == 0) begin
			r.status = srt_pkg::STATUS_EMPTY;
			due_results.push_back(r);
		end else begin
			for (int i = 0; i < stored_count; i++) begin
				r.status        = srt_pkg::STATUS_LISTED;
				r.entry_index   = i[srt_pkg::IDX_W-1:0];
				r.out_name_head = sorted_recs[i].name_head;
				r.out_name_tail = sorted_recs[i].name_tail;
				r.out_age       = sorted_recs[i].age;
				r.out_phone     = sorted_recs[i].phone;
				r.last          = (i + 1 == stored_count);
				due_results.push_back(r);
			end
		end
	endtask

	// compare one result with the oldest one due
	task automatic check_result(input srt_pkg::result_t got);
		srt_pkg::result_t want;
		if (due_results.size() == 0) begin
			report($sformatf("result %0d arrived with none due (status %0d index %0d)",
				results_seen, got.status, got.entry_index));
		end else begin
			want = due_results.pop_front();
			check_field("status", 64'(got.status), 64'(want.status));
			check_field("entry_index", 64'(got.entry_index), 64'(want.entry_index));
			check_field("out_name_head", got.out_name_head, want.out_name_head);
			check_field("out_name_tail", 64'(got.out_name_tail), 64'(want.out_name_tail));
			check_field("out_age", 64'(got.out_age), 64'(want.out_age));
			check_field("out_phone", 64'(got.out_phone), 64'(want.out_phone));
			check_field("last", 64'(got.last), 64'(want.last));
		end
		results_seen++;
	endtask

	// sample both channels at each rising edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			due_results.delete();
			stored_count   = 0;
			mismatch_total = 0;
			results_seen   = 0;
		end else begin
			if ($isunknown(strobe))
				report("strobe is unknown");
			else if (strobe)
				check_result(result);
			if (start && !busy)
				apply_request(item);
		end
		fail_count <= mismatch_total;
		pending    <= due_results.size();
		checked    <= results_seen;
	end

endmodule

`default_nettype wire

// File: tb/sorted_record_table_core_test.sv
// sorted_record_table_core_test: drives requests into the sorted record table, gives the verdict
// depends on srt_pkg, sorted_record_table_core and srt_result_checker
`default_nettype none

module sorted_record_table_core_test;

	localparam int LIMIT        = 200000;
	localparam int PHASE_ITEMS  = 62;
	localparam int SETTLE       = 50;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             start;
	srt_pkg::item_t   item;
	logic             busy;
	logic             strobe;
	srt_pkg::result_t result;

	int fail_count;
	int pending;
	int checked;
	int cycle_count;
	int insert_total;
	int list_total;

	logic [79:0] used_names [$];
	int          idle_pct_by_phase [4] = '{0, 64, 0, 35};

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	sorted_record_table_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.item   (item),
		.busy   (busy),
		.strobe (strobe),
		.result (result)
	);

	srt_result_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.item       (item),
		.strobe     (strobe),
		.result     (result),
		.fail_count (fail_count),
		.pending    (pending),
		.checked    (checked)
	);

	// hold start until the block takes the request
	task automatic transfer(input srt_pkg::item_t req);
		start <= 1'b1;
		item  <= req;
		do
			@(posedge clk);
		while (busy);
	endtask

	task automatic send_record(input logic [79:0] nm, input logic [31:0] a, p);
		srt_pkg::item_t req;
		req.mode      = srt_pkg::MODE_INSERT;
		req.name_head = nm[79:16];
		req.name_tail = nm[15:0];
		req.age       = a;
		req.phone     = p;
		transfer(req);
		insert_total++;
	endtask

	// list requests carry random payload, which the block must ignore
	task automatic send_list();
		srt_pkg::item_t req;
		req.mode      = srt_pkg::MODE_LIST;
		req.name_head = {$urandom, $urandom};
		req.name_tail = 16'($urandom);
		req.age       = $urandom;
		req.phone     = $urandom;
		transfer(req);
		list_total++;
	endtask

	// stop sending until every predicted result has come back
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	task automatic sender_gap(input int pct);
		while ($urandom_range(1, 100) <= pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		// now and then an extra pause of random length, which can span a whole insert or list
		if (pct != 0 && $urandom_range(0, 7) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 40))
				@(posedge clk);
		end
	endtask

	function automatic logic [31:0] random_word();
		case ($urandom_range(0, 11))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'hFFFF_FFFF;
			3: return 32'h0000_0000;
			default: return $urandom;
		endcase
	endfunction

	// names: raw bits, repeats of earlier names, or short names over a small alphabet
	function automatic logic [79:0] random_name();
		logic [79:0] nm;
		int          len;
		nm = '0;
		case ($urandom_range(0, 3))
			0: begin
				nm[79:48] = $urandom;
				nm[47:16] = $urandom;
				nm[15:0]  = 16'($urandom);
			end
			1: if (used_names.size() != 0)
				nm = used_names[$urandom_range(0, used_names.size() - 1)];
			default: begin
				len = $urandom_range(0, 10);
				for (int k = 0; k < len; k++)
					nm[79 - 8*k -: 8] = 8'h41 + 8'($urandom_range(0, 3));
				// bytes past the terminator must not change the order
				if (len < 9 && $urandom_range(0, 3) == 0)
					for (int k = len + 1; k < 10; k++)
						nm[79 - 8*k -: 8] = 8'($urandom);
			end
		endcase
		used_names.push_back(nm);
		return nm;
	endfunction

	// run limit
	initial begin
		cycle_count = 0;
		while (cycle_count < LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles with %0d results outstanding", LIMIT, pending);
		$display("FAILURE");
		$finish;
	end

	// stimulus
	initial begin
		arst_n       = 1'b0;
		start        = 1'b0;
		item         = '0;
		insert_total = 0;
		list_total   = 0;
		repeat (11)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty list, extreme fields and the corner cases of name order
		send_list();
		send_record({64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF}, 32'h7FFF_FFFF, 32'h8000_0000);
		send_record(80'h0, 32'h8000_0000, 32'h7FFF_FFFF);
		// empty name with junk behind the terminator ties with the empty name
		send_record({8'h00, 56'hDE_ADBE_EF01_2345, 16'h6789}, 32'h0, 32'hFFFF_FFFF);
		// equal names keep their arrival order
		send_record({16'h4142, 64'h0}, 32'd1, 32'd2);
		send_record({16'h4142, 64'h0}, 32'd3, 32'd4);
		send_record({24'h41_0058, 56'h0}, 32'd5, 32'd6);
		send_record({24'h41_0059, 56'hFF_FFFF_FFFF_FFFF}, 32'd7, 32'd8);
		// names differing only in the last byte or in the tail
		send_record(80'h4142_4344_4546_4748_494B, 32'hFFFF_FFFF, 32'h0);
		send_record(80'h4142_4344_4546_4748_494A, 32'h1234_5678, 32'h8765_4321);
		send_record(80'h4142_4344_4546_4748_5A00, 32'h5555_5555, 32'hAAAA_AAAA);
		// bytes compare unsigned
		send_record({8'h80, 72'h0}, 32'hAAAA_AAAA, 32'h5555_5555);
		send_record({8'h7F, 72'h0}, 32'h0000_0001, 32'h8000_0001);
		send_list();
		send_record({8'h01, 72'h0}, 32'h7FFF_FFFE, 32'h0000_0002);
		send_list();
		drain();

		// random: mostly inserts until full, then rejected inserts and full lists
		for (int phase = 0; phase < 4; phase++) begin
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				sender_gap(idle_pct_by_phase[phase]);
				if ($urandom_range(0, 99) < 72)
					send_record(random_name(), random_word(), random_word());
				else
					send_list();
			end
			drain();
		end

		repeat (SETTLE)
			@(posedge clk);
		$display("covered %0d inserts and %0d list requests over four sender idle phases",
			insert_total, list_total);
		$display("%0d results compared against the predicted table", checked);
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

`default_nettype wire
